// ----- rtl/ftia_pkg.sv -----
// shared types and constants for the face track id assigner
// used by ftia_cell and face_track_id_assigner; no dependencies
package ftia_pkg;

    localparam int MAX_FACES    = 16;
    localparam int COORD_W      = 12;
    localparam int CENT_W       = COORD_W + 1;
    localparam int ID_W         = 6;
    localparam int CNT_W        = $clog2(MAX_FACES + 1);
    localparam int RADIUS_W     = 12;
    localparam int MASKCNT_W    = 7;
    localparam int R2_W         = 2 * RADIUS_W;
    localparam int DIST_W       = 2 * CENT_W + 1;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 1;

    localparam logic [RADIUS_W-1:0]  RADIUS_RESET  = RADIUS_W'(100);
    localparam logic [MASKCNT_W-1:0] MASKCNT_RESET = MASKCNT_W'(1);
    localparam logic [MASKCNT_W-1:0] MASKCNT_MAX   = MASKCNT_W'(64);

    typedef enum logic [1:0] {
        REQ_FACE       = 2'd0,
        REQ_END_FRAME  = 2'd1,
        REQ_ACTIVATE   = 2'd2,
        REQ_DEACTIVATE = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MATCH_RADIUS = 1'b0,
        REG_MASK_COUNT   = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CENT_W-1:0] cx;
        logic [CENT_W-1:0] cy;
        logic [ID_W-1:0]   id;
    } entry_t;

    // search token walking down the row of cells
    typedef struct packed {
        logic              valid;
        logic [CENT_W-1:0] cx;
        logic [CENT_W-1:0] cy;
        logic              hit;
        logic [ID_W-1:0]   id;
    } probe_t;

    typedef struct packed {
        logic match_en;
        logic wr_en;
        logic copy;
    } cell_ctl_t;

endpackage

// ----- rtl/face_track_id_assigner.sv -----
// Face track id assigner: gives each detected face a tracking id.
// Input channel (in_valid/in_ready) carries one request per transaction:
// a face rectangle, end of frame, activate or deactivate. Output channel
// (out_valid/out_ready) returns exactly one result per request: mask_id,
// matched and overflow (all zero for non-face requests).
// A face centroid is registered and then walks a row of MAX_FACES cells,
// one cell per cycle; each cell compares it with its stored previous-frame
// centroid. A face is accepted, walks the row, has its result captured and
// is then issued; a non-face request skips the walk and the capture. One
// request is processed at a time; the next is accepted once the result has
// moved into the output register. If the receiver stalls, the result waits
// in the output register; a further result waits in the block (in_ready
// low) until the output register frees.
// Reset clears counters, flags and handshakes; match_radius returns to 100
// and mask_count to 1. Table contents are undefined until written.
// The user must write configuration (cfg_wr_en/cfg_index/cfg_data) only while
// idle; the block does not enforce it. Depends on ftia_pkg and ftia_cell.
module face_track_id_assigner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ftia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ftia_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [ftia_pkg::COORD_W-1:0]    face_x,
    input  logic [ftia_pkg::COORD_W-1:0]    face_y,
    input  logic [ftia_pkg::COORD_W-1:0]    face_width,
    input  logic [ftia_pkg::COORD_W-1:0]    face_height,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ftia_pkg::ID_W-1:0]       mask_id,
    output logic                            matched,
    output logic                            overflow
);
    import ftia_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    logic [RADIUS_W-1:0]    match_radius_reg;
    logic [MASKCNT_W-1:0]   mask_count_reg;
    logic [R2_W-1:0]        r2_reg, r2_next;
    probe_t                 probe_reg, probe_next;
    logic [CNT_W-1:0]       prev_count_reg, prev_count_next;
    logic [CNT_W-1:0]       cur_count_reg, cur_count_next;
    logic [ID_W-1:0]        next_id_reg, next_id_next;
    logic                   frame_seen_reg, frame_seen_next;
    logic                   is_face_reg, is_face_next;
    logic                   res_hit_reg, res_hit_next;
    logic [ID_W-1:0]        res_id_reg, res_id_next;
    logic                   out_valid_reg, out_valid_next;
    logic [ID_W-1:0]        mask_id_reg, mask_id_next;
    logic                   matched_reg, matched_next;
    logic                   overflow_reg, overflow_next;

    logic                   slot_free;
    logic                   copy_en;
    logic                   cur_wr_en;
    logic [MASKCNT_W-1:0]   live_cnt;
    logic [ID_W-1:0]        rr_id;
    logic [MASKCNT_W-1:0]   rr_inc;
    logic [ID_W-1:0]        rr_after;
    logic [ID_W-1:0]        final_id;
    logic                   cur_full;
    entry_t                 wr_entry;
    probe_t                 probe_w [MAX_FACES+1];
    cell_ctl_t              ctl     [MAX_FACES];
    logic [MAX_FACES:0]     probe_valid_vec;

    // round-robin id with clamped mask count
    always_comb
    begin
        if (mask_count_reg == '0)
        begin
            live_cnt = MASKCNT_W'(1);
        end
        else if (mask_count_reg > MASKCNT_MAX)
        begin
            live_cnt = MASKCNT_MAX;
        end
        else
        begin
            live_cnt = mask_count_reg;
        end
        rr_id    = (MASKCNT_W'(next_id_reg) >= live_cnt) ? '0 : next_id_reg;
        rr_inc   = MASKCNT_W'(rr_id) + MASKCNT_W'(1);
        rr_after = (rr_inc >= live_cnt) ? '0 : rr_inc[ID_W-1:0];
        final_id = res_hit_reg ? res_id_reg : rr_id;
        cur_full = (cur_count_reg >= CNT_W'(MAX_FACES));
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        r2_next         = r2_reg;
        probe_next      = probe_reg;
        probe_next.valid = 1'b0;
        prev_count_next = prev_count_reg;
        cur_count_next  = cur_count_reg;
        next_id_next    = next_id_reg;
        frame_seen_next = frame_seen_reg;
        is_face_next    = is_face_reg;
        res_hit_next    = res_hit_reg;
        res_id_next     = res_id_reg;
        out_valid_next  = out_valid_reg;
        mask_id_next    = mask_id_reg;
        matched_next    = matched_reg;
        overflow_next   = overflow_reg;
        copy_en         = 1'b0;
        cur_wr_en       = 1'b0;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    is_face_next = (req_t'(req_type) == REQ_FACE);
                    unique case (req_t'(req_type))
                        REQ_FACE:
                        begin
                            probe_next.valid = 1'b1;
                            probe_next.cx    = CENT_W'(face_x) + CENT_W'(face_width >> 1);
                            probe_next.cy    = CENT_W'(face_y) + CENT_W'(face_height >> 1);
                            probe_next.hit   = 1'b0;
                            probe_next.id    = '0;
                            r2_next          = R2_W'(match_radius_reg) *
                                               R2_W'(match_radius_reg);
                            state_next       = ST_WALK;
                        end
                        REQ_END_FRAME:
                        begin
                            if (frame_seen_reg && (cur_count_reg != '0))
                            begin
                                copy_en         = 1'b1;
                                prev_count_next = cur_count_reg;
                            end
                            frame_seen_next = 1'b1;
                            cur_count_next  = '0;
                            state_next      = ST_DONE;
                        end
                        REQ_ACTIVATE:
                        begin
                            frame_seen_next = 1'b0;
                            cur_count_next  = '0;
                            state_next      = ST_DONE;
                        end
                        REQ_DEACTIVATE:
                        begin
                            prev_count_next = '0;
                            cur_count_next  = '0;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (probe_w[MAX_FACES].valid)
                begin
                    res_hit_next = probe_w[MAX_FACES].hit;
                    res_id_next  = probe_w[MAX_FACES].id;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (is_face_reg)
                    begin
                        mask_id_next  = final_id;
                        matched_next  = res_hit_reg;
                        overflow_next = cur_full;
                        if (!cur_full)
                        begin
                            cur_wr_en      = 1'b1;
                            cur_count_next = cur_count_reg + CNT_W'(1);
                        end
                        if (!res_hit_reg)
                        begin
                            next_id_next = rr_after;
                        end
                    end
                    else
                    begin
                        mask_id_next  = '0;
                        matched_next  = 1'b0;
                        overflow_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            match_radius_reg <= RADIUS_RESET;
            mask_count_reg   <= MASKCNT_RESET;
            probe_reg.valid  <= 1'b0;
            prev_count_reg   <= '0;
            cur_count_reg    <= '0;
            next_id_reg      <= '0;
            frame_seen_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            probe_reg      <= probe_next;
            prev_count_reg <= prev_count_next;
            cur_count_reg  <= cur_count_next;
            next_id_reg    <= next_id_next;
            frame_seen_reg <= frame_seen_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MATCH_RADIUS: match_radius_reg <= cfg_data[RADIUS_W-1:0];
                    REG_MASK_COUNT:   mask_count_reg   <= cfg_data[MASKCNT_W-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r2_reg      <= r2_next;
        is_face_reg <= is_face_next;
        res_hit_reg <= res_hit_next;
        res_id_reg  <= res_id_next;
        mask_id_reg <= mask_id_next;
        matched_reg <= matched_next;
        overflow_reg <= overflow_next;
    end

    assign wr_entry.cx = probe_reg.cx;
    assign wr_entry.cy = probe_reg.cy;
    assign wr_entry.id = final_id;

    assign probe_w[0] = probe_reg;

    for (genvar i = 0; i < MAX_FACES; i++)
    begin : g_cell
        assign ctl[i].match_en = (CNT_W'(i) < prev_count_reg);
        assign ctl[i].wr_en    = cur_wr_en && (cur_count_reg == CNT_W'(i));
        assign ctl[i].copy     = copy_en;

        ftia_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[i]),
            .wr_entry  (wr_entry),
            .r2        (r2_reg),
            .probe_in  (probe_w[i]),
            .probe_out (probe_w[i+1])
        );
    end

    for (genvar j = 0; j <= MAX_FACES; j++)
    begin : g_vvec
        assign probe_valid_vec[j] = probe_w[j].valid;
    end

    assign out_valid = out_valid_reg;
    assign mask_id   = mask_id_reg;
    assign matched   = matched_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTHESIS
    // only one search token is ever in flight
    a_single_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(probe_valid_vec))
        else $error("more than one search token in the cell row");

    a_cur_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_count_reg <= CNT_W'(MAX_FACES))
        else $error("current table count beyond table size");

    a_probe_exit_walk: assert property (@(posedge clk) disable iff (!rst_n)
        probe_w[MAX_FACES].valid |-> (state_reg == ST_WALK))
        else $error("search token left the cell row outside the walk");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("new transaction taken while one is in progress");
`endif

endmodule

// ----- rtl/ftia_cell.sv -----
// one tracker cell: holds one previous-frame entry and one current-frame entry
// and compares the passing search token against its previous entry; uses ftia_pkg
module ftia_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ftia_pkg::cell_ctl_t       ctl,
    input  ftia_pkg::entry_t          wr_entry,
    input  logic [ftia_pkg::R2_W-1:0] r2,
    input  ftia_pkg::probe_t          probe_in,
    output ftia_pkg::probe_t          probe_out
);
    import ftia_pkg::*;

    entry_t            prev_reg;
    entry_t            cur_reg;
    probe_t            probe_reg;
    probe_t            probe_next;
    logic [CENT_W-1:0] dx;
    logic [CENT_W-1:0] dy;
    logic [DIST_W-1:0] sq_x;
    logic [DIST_W-1:0] sq_y;
    logic [DIST_W-1:0] dist_sq;
    logic              hit;

    always_comb
    begin
        dx   = (probe_in.cx > prev_reg.cx) ? probe_in.cx - prev_reg.cx
                                           : prev_reg.cx - probe_in.cx;
        dy   = (probe_in.cy > prev_reg.cy) ? probe_in.cy - prev_reg.cy
                                           : prev_reg.cy - probe_in.cy;
        sq_x = DIST_W'(dx) * DIST_W'(dx);
        sq_y = DIST_W'(dy) * DIST_W'(dy);
        dist_sq = sq_x + sq_y;
        hit  = ctl.match_en && probe_in.valid && (dist_sq < DIST_W'(r2));

        probe_next = probe_in;
        if (hit)
        begin
            probe_next.hit = 1'b1;
            probe_next.id  = prev_reg.id;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg.valid <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    // table entries stay undefined until written
    always_ff @(posedge clk)
    begin
        if (ctl.copy)
        begin
            prev_reg <= cur_reg;
        end
        if (ctl.wr_en)
        begin
            cur_reg <= wr_entry;
        end
    end

    assign probe_out = probe_reg;

endmodule

// ----- bench/face_track_id_assigner_tb.sv -----
// self-checking testbench for face_track_id_assigner: directed and random requests
// are checked against a centroid tracker model kept inside the bench
// depends on ftia_pkg and the face_track_id_assigner rtl
`timescale 1ns / 1ps

module face_track_id_assigner_tb;
    import ftia_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [ID_W-1:0] mask_id;
        logic            matched;
        logic            overflow;
    } id_result_t;

    typedef struct {
        int unsigned     cx;
        int unsigned     cy;
        logic [ID_W-1:0] id;
    } track_t;

    typedef struct {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] h;
    } rect_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MATCH_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [1:0]            req_type = REQ_FACE;
    logic [COORD_W-1:0]    face_x = '0;
    logic [COORD_W-1:0]    face_y = '0;
    logic [COORD_W-1:0]    face_width = '0;
    logic [COORD_W-1:0]    face_height = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [ID_W-1:0]       mask_id;
    logic                  matched;
    logic                  overflow;

    face_track_id_assigner dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .face_x      (face_x),
        .face_y      (face_y),
        .face_width  (face_width),
        .face_height (face_height),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .mask_id     (mask_id),
        .matched     (matched),
        .overflow    (overflow)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // tracker state mirrored by the bench
    track_t             last_tracks [MAX_FACES];
    track_t             cur_faces [MAX_FACES];
    int unsigned        prev_n = 0;
    int unsigned        cur_n = 0;
    int unsigned        rr_next = 0;
    bit                 seen_frame = 1'b0;
    logic [RADIUS_W-1:0]  radius_reg = RADIUS_RESET;
    logic [MASKCNT_W-1:0] mask_reg = MASKCNT_RESET;

    id_result_t pending_ids [$];
    rect_t      gen_prev [$];
    rect_t      gen_cur [$];

    bit idle_on = 1'b1;
    int rx_hold = 0;
    int rx_stall = 0;
    int cycle_count = 0;
    int error_count = 0;
    int items_sent = 0;
    int face_count = 0;
    int match_count = 0;
    int overflow_count = 0;
    int frame_count = 0;
    int cfg_count = 0;
    int results_seen = 0;

    function automatic id_result_t assign_id(req_t req, logic [COORD_W-1:0] x,
                                             logic [COORD_W-1:0] y, logic [COORD_W-1:0] w,
                                             logic [COORD_W-1:0] h);
        id_result_t      res;
        int unsigned     cx;
        int unsigned     cy;
        int unsigned     dx;
        int unsigned     dy;
        int unsigned     r2;
        int unsigned     ids_live;
        logic [ID_W-1:0] id;
        bit              hit;
        res = '0;
        case (req)
            REQ_FACE:
            begin
                cx = x + (w >> 1);
                cy = y + (h >> 1);
                r2 = radius_reg * radius_reg;
                hit = 1'b0;
                id = '0;
                // later entries override earlier ones
                for (int i = 0; i < prev_n; i++)
                begin
                    dx = (cx > last_tracks[i].cx) ? cx - last_tracks[i].cx
                                                  : last_tracks[i].cx - cx;
                    dy = (cy > last_tracks[i].cy) ? cy - last_tracks[i].cy
                                                  : last_tracks[i].cy - cy;
                    if (dx * dx + dy * dy < r2)
                    begin
                        hit = 1'b1;
                        id = last_tracks[i].id;
                    end
                end
                if (!hit)
                begin
                    ids_live = (mask_reg == 0) ? 1 : (mask_reg > MASKCNT_MAX) ? 64 : mask_reg;
                    if (rr_next >= ids_live)
                        rr_next = 0;
                    id = rr_next[ID_W-1:0];
                    rr_next = (rr_next + 1 >= ids_live) ? 0 : rr_next + 1;
                end
                if (cur_n < MAX_FACES)
                begin
                    cur_faces[cur_n] = '{cx, cy, id};
                    cur_n++;
                end
                else
                    res.overflow = 1'b1;
                res.mask_id = id;
                res.matched = hit;
            end
            REQ_END_FRAME:
            begin
                if (seen_frame && cur_n > 0)
                begin
                    last_tracks = cur_faces;
                    prev_n = cur_n;
                end
                seen_frame = 1'b1;
                cur_n = 0;
            end
            REQ_ACTIVATE:
            begin
                seen_frame = 1'b0;
                cur_n = 0;
            end
            default:
            begin
                prev_n = 0;
                cur_n = 0;
            end
        endcase
        return res;
    endfunction

    // one request on the input channel; returns at the accepting edge
    task automatic send_req(req_t req, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] w, logic [COORD_W-1:0] h);
        int         gap;
        id_result_t want;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        face_x <= x;
        face_y <= y;
        face_width <= w;
        face_height <= h;
        do
            @(posedge clk);
        while (!in_ready);
        want = assign_id(req, x, y, w, h);
        pending_ids = {pending_ids, want};
        items_sent++;
        if (req == REQ_FACE)
        begin
            face_count++;
            match_count += want.matched;
            overflow_count += want.overflow;
        end
        if (req == REQ_END_FRAME)
            frame_count++;
    endtask

    task automatic send_face(rect_t r);
        send_req(REQ_FACE, r.x, r.y, r.w, r.h);
        gen_cur = {gen_cur, r};
    endtask

    task automatic send_end_frame();
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        if (gen_cur.size() > 0)
            gen_prev = gen_cur;
        gen_cur.delete();
    endtask

    // drop valid and let every outstanding result come back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_ids.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_MATCH_RADIUS)
            radius_reg = data[RADIUS_W-1:0];
        else
            mask_reg = data[MASKCNT_W-1:0];
        cfg_count++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [COORD_W-1:0] near(logic [COORD_W-1:0] v, int span);
        int t;
        t = int'(v) - span + int'($urandom_range(0, 2 * span));
        if (t < 0)
            t = 0;
        if (t > 4095)
            t = 4095;
        return t[COORD_W-1:0];
    endfunction

    function automatic rect_t make_face();
        rect_t r;
        int    roll;
        roll = $urandom_range(0, 99);
        if (roll < 60 && gen_prev.size() > 0)
        begin
            r = gen_prev[$urandom_range(0, gen_prev.size() - 1)];
            r.x = near(r.x, 6);
            r.y = near(r.y, 6);
            r.w = near(r.w, 4);
            r.h = near(r.h, 4);
        end
        else if (roll < 80)
        begin
            r.x = COORD_W'($urandom);
            r.y = COORD_W'($urandom);
            r.w = COORD_W'($urandom);
            r.h = COORD_W'($urandom);
        end
        else
        begin
            r.x = COORD_W'($urandom_range(0, 600));
            r.y = COORD_W'($urandom_range(0, 600));
            r.w = COORD_W'($urandom_range(0, 200));
            r.h = COORD_W'($urandom_range(0, 200));
        end
        return r;
    endfunction

    // result checking
    always @(posedge clk)
    begin
        id_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            rx_stall = idle_on ? $urandom_range(0, 4) : 0;
            if (pending_ids.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result mask_id=%0d matched=%0b overflow=%0b",
                         $time, mask_id, matched, overflow);
            end
            else
            begin
                want = pending_ids.pop_front();
                if (mask_id !== want.mask_id)
                begin
                    error_count++;
                    $display("%0t: mask_id expected %0d actual %0d",
                             $time, want.mask_id, mask_id);
                end
                if (matched !== want.matched)
                begin
                    error_count++;
                    $display("%0t: matched expected %0b actual %0b",
                             $time, want.matched, matched);
                end
                if (overflow !== want.overflow)
                begin
                    error_count++;
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, want.overflow, overflow);
                end
            end
        end
    end

    // receiver: long hold-off first, then the per-transaction stall
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold--;
        end
        else if (rx_stall > 0)
        begin
            out_ready <= 1'b0;
            rx_stall--;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_basic_requests();
        // faces with no activation, at both extremes of every field
        send_req(REQ_FACE, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        send_req(REQ_FACE, 0, 0, 0, 0);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        send_req(REQ_ACTIVATE, 0, 0, 0, 0);
        // first frame after activation and an empty frame never replace the table
        send_req(REQ_FACE, 100, 100, 40, 40);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        cfg_write(REG_MASK_COUNT, 4);
        send_req(REQ_FACE, 100, 100, 40, 40);
        send_req(REQ_FACE, 110, 100, 40, 40);
        send_req(REQ_FACE, 1000, 1000, 2, 2);
        send_req(REQ_FACE, 4095, 0, 4095, 1);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        // both of the first two entries match here, the later one wins
        send_req(REQ_FACE, 105, 100, 40, 40);
        send_req(REQ_FACE, 1001, 999, 3, 3);
        send_req(REQ_FACE, 2000, 2000, 0, 0);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        send_req(REQ_DEACTIVATE, 0, 0, 0, 0);
        send_req(REQ_FACE, 105, 100, 40, 40);
        wait_drain();
    endtask

    task automatic test_id_limits();
        cfg_write(REG_MATCH_RADIUS, 100);
        cfg_write(REG_MASK_COUNT, 1);
        send_req(REQ_DEACTIVATE, 0, 0, 0, 0);
        send_req(REQ_FACE, 3500, 3500, 10, 10);
        cfg_write(REG_MASK_COUNT, 8);
        send_req(REQ_ACTIVATE, 0, 0, 0, 0);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        for (int k = 0; k < 7; k++)
            send_req(REQ_FACE, COORD_W'(k * 500), COORD_W'(3000 - k * 400), 20, 20);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        // counter now beyond the lowered count, and a stored id above it
        cfg_write(REG_MASK_COUNT, 3);
        send_req(REQ_FACE, 3000, 600, 20, 20);
        send_req(REQ_FACE, 4000, 4000, 0, 0);
        cfg_write(REG_MASK_COUNT, 0);
        send_req(REQ_FACE, 4000, 100, 0, 0);
        cfg_write(REG_MASK_COUNT, 12'hFFF);
        send_req(REQ_FACE, 4000, 200, 0, 0);
        send_req(REQ_FACE, 4000, 300, 0, 0);
        cfg_write(REG_MASK_COUNT, 64);
        cfg_write(REG_MATCH_RADIUS, 12'hFFF);
        send_req(REQ_FACE, 0, 0, 0, 0);
        cfg_write(REG_MATCH_RADIUS, 0);
        send_req(REQ_FACE, 1500, 1800, 20, 20);
        cfg_write(REG_MATCH_RADIUS, 1);
        send_req(REQ_FACE, 1500, 1800, 20, 20);
        wait_drain();
    endtask

    task automatic test_table_overflow();
        cfg_write(REG_MATCH_RADIUS, 50);
        cfg_write(REG_MASK_COUNT, 24);
        send_req(REQ_ACTIVATE, 0, 0, 0, 0);
        send_req(REQ_END_FRAME, 0, 0, 0, 0);
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int k = 0; k < 18; k++)
                send_req(REQ_FACE, COORD_W'((k % 6) * 600 + pass * 3),
                         COORD_W'((k / 6) * 900 + pass), COORD_W'(50 + k), COORD_W'(50 + k));
            send_req(REQ_END_FRAME, 0, 0, 0, 0);
        end
        wait_drain();
    endtask

    task automatic run_frame();
        int n;
        n = ($urandom_range(0, 99) < 6) ? $urandom_range(15, 20) : $urandom_range(0, 6);
        repeat (n) send_face(make_face());
        send_end_frame();
    endtask

    task automatic reconfigure();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            cfg_write(REG_MATCH_RADIUS, 12'hFFF);
        else if (roll == 1)
            cfg_write(REG_MATCH_RADIUS, CFG_DATA_W'($urandom_range(0, 1)));
        else if (roll < 4)
            cfg_write(REG_MATCH_RADIUS, CFG_DATA_W'($urandom));
        else
            cfg_write(REG_MATCH_RADIUS, CFG_DATA_W'($urandom_range(10, 300)));
        roll = $urandom_range(0, 9);
        if (roll == 0)
            cfg_write(REG_MASK_COUNT, 1);
        else if (roll == 1)
            cfg_write(REG_MASK_COUNT, 64);
        else if (roll == 2)
            cfg_write(REG_MASK_COUNT, CFG_DATA_W'($urandom));
        else
            cfg_write(REG_MASK_COUNT, CFG_DATA_W'($urandom_range(2, 40)));
    endtask

    task automatic test_random_traffic(int target);
        int    roll;
        int    loops;
        rect_t r;
        loops = 0;
        while (items_sent < target)
        begin
            loops++;
            if (loops % 30 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 4)
            begin
                send_req(REQ_ACTIVATE, 0, 0, 0, 0);
                gen_cur.delete();
            end
            else if (roll < 7)
                send_req(REQ_DEACTIVATE, 0, 0, 0, 0);
            else if (roll < 12)
            begin
                // noise: any request type with arbitrary fields
                repeat ($urandom_range(1, 3))
                begin
                    r.x = COORD_W'($urandom);
                    r.y = COORD_W'($urandom);
                    r.w = COORD_W'($urandom);
                    r.h = COORD_W'($urandom);
                    send_req(req_t'(2'($urandom_range(0, 3))), r.x, r.y, r.w, r.h);
                end
            end
            else if (roll < 16)
                reconfigure();
            else
                run_frame();
        end
        wait_drain();
        idle_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, filling the block
    task automatic test_output_backpressure();
        idle_on = 1'b0;
        cfg_write(REG_MATCH_RADIUS, 80);
        cfg_write(REG_MASK_COUNT, 16);
        @(posedge clk);
        rx_hold = 400;
        send_req(REQ_ACTIVATE, 0, 0, 0, 0);
        send_end_frame();
        repeat (10) send_face(make_face());
        send_end_frame();
        repeat (6) send_face(make_face());
        send_end_frame();
        wait_drain();
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_basic_requests();
        test_id_limits();
        test_table_overflow();
        test_output_backpressure();
        test_random_traffic(1500);
        test_output_backpressure();

        wait_drain();
        repeat (40) @(posedge clk);
        if (pending_ids.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d results never arrived", $time, pending_ids.size());
        end
        $display("ran %0d requests: %0d faces, %0d matched, %0d overflowed, %0d frame ends",
                 items_sent, face_count, match_count, overflow_count, frame_count);
        $display("%0d register writes, %0d results checked, %0d mismatches",
                 cfg_count, results_seen, error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
